FILE: design/bsp_pkg.sv
// package for the bit slicer with sync hunt and word packer
// shared widths, reset constants, register indexes and the slice request type
// no dependencies

package bsp_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WORD_W   = 16;
	localparam int POS_W    = 4;
	localparam int CFG_W    = 16;

	localparam logic [WORD_W-1:0] SYNC_PATTERN_RST = 16'hCEFA;
	localparam logic [WORD_W-1:0] WORD_MSB         = 16'h8000;
	localparam logic [POS_W-1:0]  POS_LAST         = 4'd15;
	localparam logic              HUNT_EN_RST      = 1'b1;

	typedef enum logic [0:0] {
		CFG_HUNT_EN      = 1'b0,
		CFG_SYNC_PATTERN = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		KIND_DATA = 1'b0,
		KIND_SYNC = 1'b1
	} kind_t;

	typedef struct packed {
		logic valid;
		logic sbit;
	} slice_t;

endpackage

FILE: design/bsp_slicer.sv
// input register and hard-decision slicer
// depends on bsp_pkg

module bsp_slicer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bsp_pkg::SAMPLE_W-1:0]  s_tdata,
	input  logic                          take,
	output bsp_pkg::slice_t               slice_s1
);

	logic sbit;

	// positive: sign clear and nonzero
	assign sbit = ~s_tdata[bsp_pkg::SAMPLE_W-1] & (|s_tdata);

	assign s_tready = ~slice_s1.valid | take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_s1.valid <= 1'b0;
			slice_s1.sbit  <= 1'b0;
		end else if (s_tready) begin
			slice_s1.valid <= s_tvalid;
			if (s_tvalid) begin
				slice_s1.sbit <= sbit;
			end
		end
	end

endmodule

FILE: design/bsp_core.sv
// sync hunt, word packer and output register
// depends on bsp_pkg; fed by bsp_slicer

module bsp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [bsp_pkg::CFG_W-1:0]   cfg_data,
	input  bsp_pkg::slice_t             slice_s1,
	output logic                        take,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bsp_pkg::WORD_W-1:0]  m_tdata,
	output logic [0:0]                  m_tuser
);

	logic [bsp_pkg::WORD_W-1:0]  sync_pattern_q;
	logic [bsp_pkg::WORD_W-1:0]  hunt_q;
	logic [bsp_pkg::WORD_W-1:0]  pack_q;
	logic [bsp_pkg::POS_W-1:0]   pos_q;
	logic                        synced_q;

	logic [bsp_pkg::WORD_W-1:0]  hunt_next;
	logic [bsp_pkg::WORD_W-1:0]  pack_next;
	logic                        match;
	logic                        word_done;
	logic                        has_result;
	logic                        out_free;

	assign hunt_next  = {hunt_q[bsp_pkg::WORD_W-2:0], slice_s1.sbit};
	assign match      = ~synced_q & (hunt_next == sync_pattern_q);
	assign pack_next  = pack_q | (slice_s1.sbit ? (bsp_pkg::WORD_MSB >> pos_q) : '0);
	assign word_done  = synced_q & (pos_q == bsp_pkg::POS_LAST);
	assign has_result = match | word_done;
	assign out_free   = ~m_tvalid | m_tready;
	assign take       = slice_s1.valid & (~has_result | out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= bsp_pkg::SYNC_PATTERN_RST;
			hunt_q         <= '0;
			pack_q         <= '0;
			pos_q          <= '0;
			synced_q       <= ~bsp_pkg::HUNT_EN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsp_pkg::CFG_HUNT_EN: begin
					// restart
					synced_q    <= ~cfg_data[0];
					hunt_q      <= '0;
					pack_q      <= '0;
					pos_q       <= '0;
				end
				bsp_pkg::CFG_SYNC_PATTERN: begin
					sync_pattern_q <= cfg_data[bsp_pkg::WORD_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (take) begin
			if (!synced_q) begin
				hunt_q <= hunt_next;
				if (match) begin
					synced_q <= 1'b1;
					pack_q   <= '0;
					pos_q    <= '0;
				end
			end else if (word_done) begin
				pack_q <= '0;
				pos_q  <= '0;
			end else begin
				pack_q <= pack_next;
				pos_q  <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take && has_result) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			if (match) begin
				m_tdata <= '0;
				m_tuser <= bsp_pkg::KIND_SYNC;
			end else begin
				m_tdata <= pack_next;
				m_tuser <= bsp_pkg::KIND_DATA;
			end
		end
	end

endmodule

FILE: design/bit_slicer_sync_packer.sv
// bit slicer with sync word hunt and 16-bit MSB-first word packer, top level
// path: a sample's bit is registered in slice_s1, and its result is then registered in the bsp_core output register
// throughput: one sample per cycle; a waiting result stalls only a sample with a result
// reset: arst_n clears the pipeline, restores hunt_en = 1 and sync_pattern = 0xCEFA
// depends on bsp_pkg, bsp_slicer, bsp_core

module bit_slicer_sync_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bsp_pkg::SAMPLE_W-1:0] s_axis_tdata,   // sample
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bsp_pkg::WORD_W-1:0]  m_axis_tdata,   // word
	output logic [0:0]                  m_axis_tuser,   // kind
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [bsp_pkg::CFG_W-1:0]   cfg_data
);

	bsp_pkg::slice_t slice_s1;
	logic            take;

	bsp_slicer u_slicer (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.take     (take),
		.slice_s1 (slice_s1)
	);

	bsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.slice_s1  (slice_s1),
		.take      (take),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser)
	);

`ifndef SYNTHESIS
	// a sync event always carries a zero word
	a_sync_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == bsp_pkg::KIND_SYNC) |-> (m_axis_tdata == '0))
		else $error("sync event with nonzero word");

	// once a sync is delivered, the next cycle cannot show another sync without a restart
	a_no_back_to_back_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == bsp_pkg::KIND_SYNC && !cfg_we)
		##1 !cfg_we |-> !(m_axis_tvalid && m_axis_tuser == bsp_pkg::KIND_SYNC))
		else $error("second sync event without restart");
`endif

endmodule
